>>> hw/rtl/ansc_pkg.sv
package ansc_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 4194304;
	localparam int unsigned POS_W = 23;
	localparam int unsigned EXT_W = POS_W + 1;

	localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
	localparam logic [4:0] NAL_TYPE_IDR = 5'h05;
	localparam logic [7:0] START_MARK = 8'h01;
	localparam logic [2:0] START_ZEROS = 3'd3;
	localparam logic [2:0] ZERO_RUN_MAX = 3'd4;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME_BYTES - 1);

	// result queue: room for two items in flight, each with up to two results
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW = FIFO_AW + 1;
	localparam logic [FIFO_CW-1:0] FIFO_ROOM = FIFO_CW'(FIFO_DEPTH - 4);

	typedef struct packed {
		logic             nal_valid;
		logic [POS_W-1:0] nal_offset;
		logic [POS_W-1:0] nal_length;
		logic             key_frame;
		logic             frame_end;
	} nal_res_t;

	typedef struct packed {
		logic [1:0] n;
		nal_res_t   r0;
		nal_res_t   r1;
	} push_t;

endpackage

>>> hw/rtl/ansc_byte_if.sv
interface ansc_byte_if;
	import ansc_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);

endinterface

>>> hw/rtl/ansc_nal_if.sv
interface ansc_nal_if;
	import ansc_pkg::*;

	logic             valid;
	logic             ready;
	logic             nal_valid;
	logic [POS_W-1:0] nal_offset;
	logic [POS_W-1:0] nal_length;
	logic             key_frame;
	logic             frame_end;

	modport source (output valid, output nal_valid, output nal_offset, output nal_length,
		output key_frame, output frame_end, input ready);
	modport sink (input valid, input nal_valid, input nal_offset, input nal_length,
		input key_frame, input frame_end, output ready);

endinterface

>>> hw/rtl/annexb_nal_start_code_scanner.sv
// Annex B start code scanner: takes one byte of an encoded H.264 frame per transfer on
// bytes, with final_byte set on the frame's last byte, and reports each NAL unit as an
// offset (just after its four-byte start code) and a length on results. Each start code
// after the first reports the unit before it; the last byte reports the open unit, or a
// result with nal_valid low if no start code was seen, with frame_end set and key_frame
// high if an IDR header (type 5) was found. A byte is taken every cycle while bytes.ready
// is high; it passes an input register and combinational scan logic into an eight-entry
// result queue that holds each result until it is taken. bytes.ready drops only when
// the result queue holds more than four entries waiting to be taken.
module annexb_nal_start_code_scanner
	import ansc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ansc_byte_if.sink   bytes,
	ansc_nal_if.source  results
);

	push_t push;
	logic  room;

	ansc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.room   (room),
		.push   (push)
	);

	ansc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.results (results)
	);

endmodule

>>> hw/rtl/ansc_scan.sv
module ansc_scan
	import ansc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	ansc_byte_if.sink     bytes,
	input  logic          room,
	output push_t         push
);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             final_s1;

	logic [POS_W-1:0] pos_q;
	logic [2:0]       zrun_q;
	logic [POS_W-1:0] start_q;
	logic             key_q;

	logic             accept;
	logic             hdr_idr;
	logic             key_n;
	logic             sc;
	logic [POS_W-1:0] start_n;
	logic [EXT_W-1:0] pos_ext;
	logic [EXT_W-1:0] pos_p1;
	logic [EXT_W-1:0] start3;
	logic [EXT_W-1:0] start_n_ext;
	logic [EXT_W-1:0] len_mid;
	logic [EXT_W-1:0] len_last;
	nal_res_t         res_mid;
	nal_res_t         res_last;
	logic             mid_en;

	assign bytes.ready = room;
	assign accept = bytes.valid & room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= bytes.data_byte;
			final_s1 <= bytes.final_byte;
		end
	end

	always_comb begin
		hdr_idr = (pos_q != '0) && (pos_q == start_q) &&
			((data_s1[4:0] & NAL_TYPE_MASK) == NAL_TYPE_IDR);
		key_n = key_q | hdr_idr;
		sc = (data_s1 == START_MARK) && (zrun_q == START_ZEROS);
		mid_en = sc && (start_q != '0);
		start_n = sc ? (pos_q + 1'b1) : start_q;

		pos_ext = {1'b0, pos_q};
		pos_p1 = pos_ext + 1'b1;
		start3 = {1'b0, start_q} + EXT_W'(START_ZEROS);
		start_n_ext = {1'b0, start_n};
		len_mid = (pos_ext > start3) ? (pos_ext - start3) : '0;
		len_last = (pos_p1 > start_n_ext) ? (pos_p1 - start_n_ext) : '0;

		res_mid.nal_valid = 1'b1;
		res_mid.nal_offset = start_q;
		res_mid.nal_length = len_mid[POS_W-1:0];
		res_mid.key_frame = 1'b0;
		res_mid.frame_end = 1'b0;

		res_last.nal_valid = (start_n != '0);
		res_last.nal_offset = (start_n != '0) ? start_n : '0;
		res_last.nal_length = (start_n != '0) ? len_last[POS_W-1:0] : '0;
		res_last.key_frame = key_n;
		res_last.frame_end = 1'b1;

		push.r0 = mid_en ? res_mid : res_last;
		push.r1 = res_last;
		if (!valid_s1) begin
			push.n = 2'd0;
		end else begin
			push.n = 2'(mid_en) + 2'(final_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			zrun_q <= '0;
			start_q <= '0;
			key_q <= 1'b0;
		end else if (valid_s1) begin
			if (final_s1) begin
				pos_q <= '0;
				zrun_q <= '0;
				start_q <= '0;
				key_q <= 1'b0;
			end else begin
				if (pos_q < POS_LAST) begin
					pos_q <= pos_q + 1'b1;
				end
				if (data_s1 == 8'h00) begin
					if (zrun_q < ZERO_RUN_MAX) begin
						zrun_q <= zrun_q + 1'b1;
					end
				end else begin
					zrun_q <= '0;
				end
				start_q <= start_n;
				key_q <= key_n;
			end
		end
	end

endmodule

>>> hw/rtl/ansc_fifo.sv
module ansc_fifo
	import ansc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        room,
	ansc_nal_if.source  results
);

	nal_res_t           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] head_q;
	logic [FIFO_AW-1:0] tail_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;
	nal_res_t           head_res;

	assign pop = results.valid & results.ready;
	// worst case: item in the input register plus the one being taken
	assign room = (count_q <= FIFO_ROOM);

	assign head_res = mem_q[head_q];
	assign results.valid = (count_q != '0);
	assign results.nal_valid = head_res.nal_valid;
	assign results.nal_offset = head_res.nal_offset;
	assign results.nal_length = head_res.nal_length;
	assign results.key_frame = head_res.key_frame;
	assign results.frame_end = head_res.frame_end;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[tail_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[tail_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			tail_q <= tail_q + FIFO_AW'(push.n);
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			count_q <= count_q + FIFO_CW'(push.n) - FIFO_CW'(pop);
		end
	end

endmodule
